// ===== src/pra_pkg.sv =====
// Shared constants, codes and types of the priority resource allocator.
package pra_pkg;

    localparam int SERVICES    = 4;
    localparam int WORKERS     = 8;
    localparam int AMOUNT_BITS = 16;
    localparam int ENTRIES     = SERVICES * WORKERS;
    localparam int ADDR_W      = $clog2(ENTRIES);

    localparam int OP_W   = 2;
    localparam int SVC_W  = 2;
    localparam int SLOT_W = 3;
    localparam int PRIO_W = 8;
    localparam int AMT_W  = AMOUNT_BITS;
    localparam int STAT_W = 3;

    // stream packing
    localparam int IN_OP_LSB    = 0;
    localparam int IN_SVC_LSB   = IN_OP_LSB + OP_W;
    localparam int IN_SLOT_LSB  = IN_SVC_LSB + SVC_W;
    localparam int IN_PRIO_LSB  = IN_SLOT_LSB + SLOT_W;
    localparam int IN_AMT_LSB   = IN_PRIO_LSB + PRIO_W;
    localparam int IN_USED_W    = IN_AMT_LSB + AMT_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = STAT_W + SLOT_W + AMT_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ASSIGNED = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_REJECTED = 3'd2,
        ST_LOADED   = 3'd3,
        ST_RELEASED = 3'd4
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [AMT_W-1:0]  cap;
        logic [AMT_W-1:0]  avail;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        slot_entry_t       data;
    } mem_wr_t;

    typedef struct packed {
        logic             avail_ge;   // available >= amount
        logic             cap_ge;     // capacity >= amount
        logic [AMT_W-1:0] diff;       // available - amount
        logic [AMT_W-1:0] rel_val;    // available + amount, saturated at capacity
    } alu_res_t;

endpackage

// ===== src/priority_resource_allocator_core.sv =====
// Top level: request sequencer of the priority first-fit resource allocator.
//
//  channel  | dir | handshake          | payload (lowest bit first)
//  ---------+-----+--------------------+-----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | opcode[2] service_index[2] slot_index[3]
//           |     |                    | priority_value[8] amount[16], zero pad to 32
//  m_*      | out | m_tvalid/m_tready  | status[3] chosen_slot[3] remaining[16], pad to 24
//
// A load writes the slot from decode; a release reads it, then writes it back; in a
// request the slots of the service are read one per cycle through the single table
// read port and judged by the shared amount unit, then the winner is written back.
// Reset clears the valid bits and the sequencer; the table contents need no clear.
// s_tready is high only while the sequencer is idle. A finished result sits in the
// output register; the sequencer holds in its last state while that register is full.
module priority_resource_allocator_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // opcode, service_index, slot_index, priority_value, amount
    input  logic [pra_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, chosen_slot, remaining
    output logic [pra_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_END,
        S_COMMIT,
        S_REL_EVAL
    } state_t;

    state_t                            state_reg, state_next;

    // latched request
    pra_pkg::opcode_t                  op_reg, op_next;
    logic [pra_pkg::SVC_W-1:0]         svc_reg, svc_next;
    logic [pra_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [pra_pkg::PRIO_W-1:0]        prio_reg, prio_next;
    logic [pra_pkg::AMT_W-1:0]         amt_reg, amt_next;

    // scan state
    logic [pra_pkg::SLOT_W-1:0]        cnt_reg, cnt_next;
    logic                              ev_vld_reg, ev_vld_next;
    logic [pra_pkg::SLOT_W-1:0]        ev_idx_reg, ev_idx_next;
    logic                              found_reg, found_next;
    logic                              could_reg, could_next;
    logic [pra_pkg::SLOT_W-1:0]        best_idx_reg, best_idx_next;
    logic [pra_pkg::PRIO_W-1:0]        best_prio_reg, best_prio_next;
    logic [pra_pkg::AMT_W-1:0]         best_cap_reg, best_cap_next;
    logic [pra_pkg::AMT_W-1:0]         best_rem_reg, best_rem_next;

    // result register
    logic                              m_valid_reg, m_valid_next;
    pra_pkg::status_t                  m_status_reg, m_status_next;
    logic [pra_pkg::SLOT_W-1:0]        m_slot_reg, m_slot_next;
    logic [pra_pkg::AMT_W-1:0]         m_rem_reg, m_rem_next;

    // table and shared unit
    pra_pkg::mem_wr_t                  wr;
    logic                              rd_en;
    logic [pra_pkg::SLOT_W-1:0]        rd_idx;
    logic [pra_pkg::ADDR_W-1:0]        rd_addr;
    pra_pkg::slot_entry_t              rd_entry;
    logic                              rd_valid;
    pra_pkg::alu_res_t                 alu;

    logic                              svc_ok;
    logic                              slot_ok;
    logic                              out_free;
    logic                              evaluating;

    assign svc_ok   = (32'(svc_reg) < pra_pkg::SERVICES);
    assign slot_ok  = svc_ok && (32'(slot_reg) < pra_pkg::WORKERS);
    assign out_free = !m_valid_reg || m_tready;

    assign rd_idx  = (state_reg == S_SCAN) ? cnt_reg : slot_reg;
    assign rd_addr = pra_pkg::ADDR_W'(32'(svc_reg) * pra_pkg::WORKERS + 32'(rd_idx));

    // a valid slot read last cycle is judged this cycle
    assign evaluating = ((state_reg == S_SCAN) || (state_reg == S_SCAN_END))
                        && ev_vld_reg && rd_valid;

    pra_slot_mem u_slot_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    pra_amt_alu u_amt_alu
    (
        .avail (rd_entry.avail),
        .cap   (rd_entry.cap),
        .amt   (amt_reg),
        .res   (alu)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        svc_next       = svc_reg;
        slot_next      = slot_reg;
        prio_next      = prio_reg;
        amt_next       = amt_reg;
        cnt_next       = cnt_reg;
        ev_vld_next    = ev_vld_reg;
        ev_idx_next    = ev_idx_reg;
        found_next     = found_reg;
        could_next     = could_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_cap_next  = best_cap_reg;
        best_rem_next  = best_rem_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_slot_next    = m_slot_reg;
        m_rem_next     = m_rem_reg;
        rd_en          = 1'b0;
        wr             = '0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        // priority-first-fit judgement of one slot
        if (evaluating)
        begin
            if (alu.cap_ge)
                could_next = 1'b1;
            if (alu.avail_ge && (!found_reg || (rd_entry.prio < best_prio_reg)))
            begin
                found_next     = 1'b1;
                best_idx_next  = ev_idx_reg;
                best_prio_next = rd_entry.prio;
                best_cap_next  = rd_entry.cap;
                best_rem_next  = alu.diff;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = pra_pkg::opcode_t'(s_tdata[pra_pkg::IN_OP_LSB +: pra_pkg::OP_W]);
                    svc_next   = s_tdata[pra_pkg::IN_SVC_LSB +: pra_pkg::SVC_W];
                    slot_next  = s_tdata[pra_pkg::IN_SLOT_LSB +: pra_pkg::SLOT_W];
                    prio_next  = s_tdata[pra_pkg::IN_PRIO_LSB +: pra_pkg::PRIO_W];
                    amt_next   = s_tdata[pra_pkg::IN_AMT_LSB +: pra_pkg::AMT_W];
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (op_reg)
                    pra_pkg::OP_LOAD:
                    begin
                        if (out_free)
                        begin
                            if (slot_ok)
                            begin
                                wr.en         = 1'b1;
                                wr.addr       = rd_addr;
                                wr.data.prio  = prio_reg;
                                wr.data.cap   = amt_reg;
                                wr.data.avail = amt_reg;
                            end
                            m_valid_next  = 1'b1;
                            m_status_next = pra_pkg::ST_LOADED;
                            m_slot_next   = slot_reg;
                            m_rem_next    = slot_ok ? amt_reg : '0;
                            state_next    = S_IDLE;
                        end
                    end

                    pra_pkg::OP_REQUEST:
                    begin
                        cnt_next    = '0;
                        ev_vld_next = 1'b0;
                        found_next  = 1'b0;
                        could_next  = 1'b0;
                        // unknown service: nothing fits, commit rejects
                        state_next  = svc_ok ? S_SCAN : S_COMMIT;
                    end

                    pra_pkg::OP_RELEASE:
                    begin
                        if (slot_ok)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_REL_EVAL;
                        end
                        else if (out_free)
                        begin
                            m_valid_next  = 1'b1;
                            m_status_next = pra_pkg::ST_RELEASED;
                            m_slot_next   = slot_reg;
                            m_rem_next    = '0;
                            state_next    = S_IDLE;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            m_valid_next  = 1'b1;
                            m_status_next = pra_pkg::ST_REJECTED;
                            m_slot_next   = '0;
                            m_rem_next    = '0;
                            state_next    = S_IDLE;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                rd_en       = 1'b1;
                ev_vld_next = 1'b1;
                ev_idx_next = cnt_reg;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == pra_pkg::SLOT_W'(pra_pkg::WORKERS - 1))
                    state_next = S_SCAN_END;
            end

            S_SCAN_END:
            begin
                ev_vld_next = 1'b0;
                state_next  = S_COMMIT;
            end

            S_COMMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = pra_pkg::ADDR_W'(32'(svc_reg) * pra_pkg::WORKERS
                                                         + 32'(best_idx_reg));
                        wr.data.prio  = best_prio_reg;
                        wr.data.cap   = best_cap_reg;
                        wr.data.avail = best_rem_reg;
                        m_status_next = pra_pkg::ST_ASSIGNED;
                        m_slot_next   = best_idx_reg;
                        m_rem_next    = best_rem_reg;
                    end
                    else
                    begin
                        m_status_next = could_reg ? pra_pkg::ST_BLOCKED : pra_pkg::ST_REJECTED;
                        m_slot_next   = '0;
                        m_rem_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            S_REL_EVAL:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = pra_pkg::ST_RELEASED;
                    m_slot_next   = slot_reg;
                    if (rd_valid)
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = rd_addr;
                        wr.data.prio  = rd_entry.prio;
                        wr.data.cap   = rd_entry.cap;
                        wr.data.avail = alu.rel_val;
                        m_rem_next    = alu.rel_val;
                    end
                    else
                    begin
                        // release to an empty slot is dropped
                        m_rem_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ev_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            could_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ev_vld_reg  <= ev_vld_next;
            found_reg   <= found_next;
            could_reg   <= could_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        svc_reg       <= svc_next;
        slot_reg      <= slot_next;
        prio_reg      <= prio_next;
        amt_reg       <= amt_next;
        ev_idx_reg    <= ev_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_cap_reg  <= best_cap_next;
        best_rem_reg  <= best_rem_next;
        m_status_reg  <= m_status_next;
        m_slot_reg    <= m_slot_next;
        m_rem_reg     <= m_rem_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{pra_pkg::OUT_PAD_W{1'b0}}, m_rem_reg, m_slot_reg, m_status_reg};

endmodule

// ===== src/pra_slot_mem.sv =====
// Worker slot table: one write port, one registered read port, valid bits in flops.
module pra_slot_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pra_pkg::mem_wr_t              wr,
    input  logic                          rd_en,
    input  logic [pra_pkg::ADDR_W-1:0]    rd_addr,
    output pra_pkg::slot_entry_t          rd_entry,
    output logic                          rd_valid
);

    pra_pkg::slot_entry_t             entry_mem [pra_pkg::ENTRIES];
    logic [pra_pkg::ENTRIES-1:0]      valid_reg;
    logic                             rd_valid_reg;
    pra_pkg::slot_entry_t             rd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            entry_mem[wr.addr] <= wr.data;
        if (rd_en)
            rd_entry_reg <= entry_mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== src/pra_amt_alu.sv =====
// Shared amount unit: fit compares, deduction and saturating give-back.
module pra_amt_alu
(
    input  logic [pra_pkg::AMT_W-1:0] avail,
    input  logic [pra_pkg::AMT_W-1:0] cap,
    input  logic [pra_pkg::AMT_W-1:0] amt,
    output pra_pkg::alu_res_t         res
);

    logic [pra_pkg::AMT_W:0] sum;
    logic                    sat;

    assign sum = {1'b0, avail} + {1'b0, amt};
    // full when already over capacity or the sum reaches it
    assign sat = (cap < avail) || (sum >= {1'b0, cap});

    assign res.avail_ge = (avail >= amt);
    assign res.cap_ge   = (cap >= amt);
    assign res.diff     = avail - amt;
    assign res.rel_val  = sat ? cap : sum[pra_pkg::AMT_W-1:0];

endmodule
